>>> hw/rtl/cpa_pkg.sv
// shared types and constants for the contiguous page allocator
// no dependencies; imported by the interfaces and every allocator module

package cpa_pkg;

  localparam int BYTES_W    = 32;
  localparam int RES_ADDR_W = 32;
  localparam int SHIFT_W    = 5;
  localparam int PAGES_W    = 9;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // bytes >> 4 plus round-up fits in 29 bits
  localparam int NEED_W     = 29;

  // free bitmap is stored in words of this many pages
  localparam int WORD_BITS  = 8;
  localparam int WORD_LOG2  = 3;

  localparam logic [SHIFT_W-1:0]    SHIFT_MIN  = 5'd4;
  localparam logic [SHIFT_W-1:0]    SHIFT_MAX  = 5'd16;
  localparam logic [SHIFT_W-1:0]    SHIFT_RST  = 5'd12;
  localparam logic [PAGES_W-1:0]    PAGES_RST  = 9'd256;
  localparam logic [RES_ADDR_W-1:0] BASE_RST   = 32'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_ENOUGH   = 3'd1,
    ST_NO_RUN       = 3'd2,
    ST_FREE_IGNORED = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_ZERO_SIZE    = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SHIFT = 2'd0,
    CFG_PAGES      = 2'd1,
    CFG_BASE       = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    decode;
    logic    clr_start;
    logic    clr_step;
    logic    scan_start;
    logic    scan_step;
    logic    alloc_set;
    logic    free_rd;
    logic    free_set;
    logic    range_step;
    logic    load_out;
    status_e status;
  } cpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cfg_hit;
    logic cmd_free;
    logic clr_last;
    logic zero_size;
    logic not_enough;
    logic oor;
    logic scan_found;
    logic scan_end;
    logic free_ignored;
    logic range_last;
  } cpa_sts_t;

endpackage

>>> hw/rtl/cpa_if.sv
// request, response and configuration channel interfaces
// depends on cpa_pkg

interface cpa_req_if import cpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [BYTES_W-1:0]   request_bytes;
  logic [BYTES_W-1:0]   release_address;

  modport source (output valid, output cmd, output request_bytes, output release_address,
                  input ready);
  modport sink   (input valid, input cmd, input request_bytes, input release_address,
                  output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [RES_ADDR_W-1:0] result_address;
  logic [PAGES_W-1:0]    run_pages;
  logic [PAGES_W-1:0]    free_pages;

  modport source (output valid, output status, output result_address, output run_pages,
                  output free_pages, input ready);
  modport sink   (input valid, input status, input result_address, input run_pages,
                  input free_pages, output ready);
endinterface

interface cpa_cfg_if import cpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/cpa_dp.sv
// allocator datapath: config registers, free bitmap and run length memories,
// scan counters, range writer and result register; depends on cpa_pkg

module cpa_dp import cpa_pkg::*; #(
  parameter int MAX_PAGES  = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpa_cmd_t              cmd_i,
  output cpa_sts_t              sts_o,
  input  logic                  in_cmd_i,
  input  logic [BYTES_W-1:0]    in_bytes_i,
  input  logic [BYTES_W-1:0]    in_addr_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [RES_ADDR_W-1:0] result_address_o,
  output logic [PAGES_W-1:0]    run_pages_o,
  output logic [PAGES_W-1:0]    free_pages_o
);

  localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NW  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int QW  = $clog2(MAX_PAGES + WORD_BITS) + 1;
  localparam int RW  = $clog2(MAX_PAGES + 1);
  localparam int EW  = (QW > PAGES_W) ? QW : PAGES_W;
  localparam int AMW = (ADDR_WIDTH < RES_ADDR_W) ? ADDR_WIDTH : RES_ADDR_W;
  localparam logic [RES_ADDR_W-1:0] ADDR_MASK = RES_ADDR_W'((64'd1 << AMW) - 64'd1);

  // config registers
  logic [SHIFT_W-1:0]    shift_q;
  logic [PAGES_W-1:0]    pages_q;
  logic [RES_ADDR_W-1:0] base_q;

  // request registers
  logic                  cmd_q;
  logic [BYTES_W-1:0]    bytes_q;
  logic [BYTES_W-1:0]    rel_q;
  logic [NEED_W-1:0]     need_q;
  logic                  oor_q;
  logic [QW-1:0]         idx_q;

  // pool state and work counters
  logic [QW-1:0]         free_cnt_q;
  logic [PW-1:0]         clr_q;
  logic [WW-1:0]         scan_w_q;
  logic [QW-1:0]         scan_cnt_q;
  logic [QW-1:0]         scan_st_q;
  logic [QW-1:0]         lo_q;
  logic [QW-1:0]         hi_q;
  logic [WW-1:0]         wr_w_q;
  logic                  set_val_q;
  logic [QW-1:0]         run_q;
  logic [RES_ADDR_W-1:0] addr_q;

  // result register
  logic [STATUS_W-1:0]   res_status_q;
  logic [RES_ADDR_W-1:0] res_addr_q;
  logic [PAGES_W-1:0]    res_run_q;
  logic [PAGES_W-1:0]    res_free_q;

  // memories
  logic [WORD_BITS-1:0]  fmap_mem [NW];
  logic [RW-1:0]         rl_mem [MAX_PAGES];
  logic [WORD_BITS-1:0]  fm_rdata_q;
  logic [RW-1:0]         rl_rdata_q;

  logic [SHIFT_W-1:0]    eff_sh;
  logic [EW-1:0]         pages_ext;
  logic [QW-1:0]         np;
  logic [QW-1:0]         np_m1, np_m1_sh, idx_sh, st_sh, hi_m1, hi_sh, clr_sh;
  logic [WW-1:0]         last_w, idx_w, st_w, hi_w, clr_w;
  logic [BYTES_W-1:0]    byte_hi, byte_lo;
  logic [NEED_W-1:0]     need_d;
  logic [BYTES_W:0]      off;
  logic [BYTES_W-1:0]    idx_full;
  logic                  oor_d;
  logic [QW-1:0]         need_pg;
  logic [QW-1:0]         sc_cnt, sc_st, sc_p;
  logic                  sc_found;
  logic [QW-1:0]         rg_p;
  logic [WORD_BITS-1:0]  rg_mask;
  logic                  bit_free;
  logic [QW-1:0]         rl_val, avail, span;
  logic                  fm_we;
  logic [WW-1:0]         fm_waddr, fm_raddr;
  logic [WORD_BITS-1:0]  fm_wmask, fm_wdata;
  logic                  rl_we;
  logic [PW-1:0]         rl_waddr;
  logic [RW-1:0]         rl_wdata;
  logic                  cfg_hit;

  // effective page size and page count
  always_comb begin
    if (shift_q < SHIFT_MIN) begin
      eff_sh = SHIFT_MIN;
    end else if (shift_q > SHIFT_MAX) begin
      eff_sh = SHIFT_MAX;
    end else begin
      eff_sh = shift_q;
    end
    pages_ext = EW'(pages_q);
    if (pages_ext > EW'(MAX_PAGES)) begin
      np = QW'(MAX_PAGES);
    end else begin
      np = QW'(pages_ext);
    end
  end

  // page index to bitmap word
  assign np_m1    = np - QW'(1);
  assign np_m1_sh = np_m1 >> WORD_LOG2;
  assign last_w   = np_m1_sh[WW-1:0];
  assign idx_sh   = idx_q >> WORD_LOG2;
  assign idx_w    = idx_sh[WW-1:0];
  assign st_sh    = scan_st_q >> WORD_LOG2;
  assign st_w     = st_sh[WW-1:0];
  assign hi_m1    = hi_q - QW'(1);
  assign hi_sh    = hi_m1 >> WORD_LOG2;
  assign hi_w     = hi_sh[WW-1:0];
  assign clr_sh   = QW'(clr_q) >> WORD_LOG2;
  assign clr_w    = clr_sh[WW-1:0];

  // round bytes up to pages; translate release address to page index
  always_comb begin
    byte_hi  = bytes_q >> eff_sh;
    byte_lo  = bytes_q & ~({BYTES_W{1'b1}} << eff_sh);
    need_d   = NEED_W'(byte_hi) + NEED_W'(byte_lo != '0);
    off      = {1'b0, rel_q} - {1'b0, base_q};
    idx_full = off[BYTES_W-1:0] >> eff_sh;
    oor_d    = off[BYTES_W] || (idx_full >= BYTES_W'(np));
  end

  assign need_pg = QW'(need_q);

  // first-fit scan over one bitmap word
  always_comb begin
    sc_cnt   = scan_cnt_q;
    sc_st    = scan_st_q;
    sc_found = 1'b0;
    sc_p     = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      sc_p = (QW'(scan_w_q) << WORD_LOG2) | QW'(b);
      if (!sc_found && (sc_p < np)) begin
        if (fm_rdata_q[b]) begin
          if (sc_cnt == '0) begin
            sc_st = sc_p;
          end
          sc_cnt = sc_cnt + QW'(1);
          if (sc_cnt == need_pg) begin
            sc_found = 1'b1;
          end
        end else begin
          sc_cnt = '0;
        end
      end
    end
  end

  // bits of the current word that fall inside [lo, hi)
  always_comb begin
    rg_mask = '0;
    rg_p    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      rg_p       = (QW'(wr_w_q) << WORD_LOG2) | QW'(b);
      rg_mask[b] = (rg_p >= lo_q) && (rg_p < hi_q);
    end
  end

  // free request check and released span
  always_comb begin
    bit_free = fm_rdata_q[idx_q[WORD_LOG2-1:0]];
    rl_val   = QW'(rl_rdata_q);
    avail    = np - idx_q;
    span     = (rl_val > avail) ? avail : rl_val;
  end

  // memory ports
  always_comb begin
    if (cmd_i.scan_step) begin
      fm_raddr = scan_w_q + WW'(1);
    end else if (cmd_i.free_rd) begin
      fm_raddr = idx_w;
    end else begin
      fm_raddr = '0;
    end
    fm_we    = cmd_i.clr_step || cmd_i.range_step;
    fm_waddr = cmd_i.clr_step ? clr_w : wr_w_q;
    fm_wmask = cmd_i.clr_step ? {WORD_BITS{1'b1}} : rg_mask;
    fm_wdata = cmd_i.clr_step ? {WORD_BITS{1'b1}} : {WORD_BITS{set_val_q}};
    rl_we    = cmd_i.clr_step || cmd_i.alloc_set || cmd_i.free_set;
    if (cmd_i.clr_step) begin
      rl_waddr = clr_q;
    end else if (cmd_i.alloc_set) begin
      rl_waddr = scan_st_q[PW-1:0];
    end else begin
      rl_waddr = idx_q[PW-1:0];
    end
    rl_wdata = cmd_i.alloc_set ? RW'(need_pg) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (fm_wmask[b]) begin
          fmap_mem[fm_waddr][b] <= fm_wdata[b];
        end
      end
    end
    fm_rdata_q <= fmap_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[rl_waddr] <= rl_wdata;
    end
    rl_rdata_q <= rl_mem[idx_q[PW-1:0]];
  end

  // a write beyond the register list leaves the pool alone
  always_comb begin
    case (cfg_idx_i)
      CFG_PAGE_SHIFT, CFG_PAGES, CFG_BASE: cfg_hit = cfg_we_i;
      default:                             cfg_hit = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q    <= SHIFT_RST;
      pages_q    <= PAGES_RST;
      base_q     <= BASE_RST;
      free_cnt_q <= '0;
      clr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_SHIFT: shift_q <= cfg_data_i[SHIFT_W-1:0];
          CFG_PAGES:      pages_q <= cfg_data_i[PAGES_W-1:0];
          CFG_BASE:       base_q  <= cfg_data_i[RES_ADDR_W-1:0];
          default:        ;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + PW'(1);
        if (sts_o.clr_last) begin
          free_cnt_q <= np;
        end
      end
      if (cmd_i.alloc_set) begin
        free_cnt_q <= free_cnt_q - need_pg;
      end else if (cmd_i.free_set) begin
        free_cnt_q <= free_cnt_q + span;
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= in_cmd_i;
      bytes_q <= in_bytes_i;
      rel_q   <= in_addr_i;
      run_q   <= '0;
      addr_q  <= '0;
    end
    if (cmd_i.decode) begin
      need_q <= need_d;
      oor_q  <= oor_d;
      idx_q  <= QW'(idx_full);
    end
    if (cmd_i.scan_start) begin
      scan_w_q   <= '0;
      scan_cnt_q <= '0;
      scan_st_q  <= '0;
    end else if (cmd_i.scan_step) begin
      scan_w_q   <= scan_w_q + WW'(1);
      scan_cnt_q <= sc_cnt;
      scan_st_q  <= sc_st;
    end
    if (cmd_i.alloc_set) begin
      lo_q      <= scan_st_q;
      hi_q      <= scan_st_q + need_pg;
      wr_w_q    <= st_w;
      set_val_q <= 1'b0;
      run_q     <= need_pg;
      addr_q    <= (base_q + (RES_ADDR_W'(scan_st_q) << eff_sh)) & ADDR_MASK;
    end else if (cmd_i.free_set) begin
      lo_q      <= idx_q;
      hi_q      <= idx_q + span;
      wr_w_q    <= idx_w;
      set_val_q <= 1'b1;
      run_q     <= rl_val;
    end else if (cmd_i.range_step) begin
      wr_w_q <= wr_w_q + WW'(1);
    end
    if (cmd_i.load_out) begin
      res_status_q <= cmd_i.status;
      res_addr_q   <= addr_q;
      res_run_q    <= PAGES_W'(run_q);
      res_free_q   <= PAGES_W'(free_cnt_q);
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.cfg_hit      = cfg_hit;
    sts_o.cmd_free     = (cmd_q == CMD_FREE);
    sts_o.clr_last     = (clr_q == PW'(MAX_PAGES - 1));
    sts_o.zero_size    = (need_q == '0);
    sts_o.not_enough   = (NEED_W'(free_cnt_q) < need_q);
    sts_o.oor          = oor_q;
    sts_o.scan_found   = sc_found;
    sts_o.scan_end     = (scan_w_q == last_w);
    sts_o.free_ignored = bit_free || (rl_rdata_q == '0);
    sts_o.range_last   = (wr_w_q == hi_w);
  end

  assign status_o         = res_status_q;
  assign result_address_o = res_addr_q;
  assign run_pages_o      = res_run_q;
  assign free_pages_o     = res_free_q;

endmodule

>>> hw/rtl/cpa_ctrl.sv
// allocator controller: sequences clearing, scan, range writes and result hand-off
// depends on cpa_pkg; drives cpa_dp through cpa_cmd_t

module cpa_ctrl import cpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cpa_sts_t sts_i,
  output cpa_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC_CHK,
    S_SCAN,
    S_ALLOC_SET,
    S_FREE_RD,
    S_FREE_CHK,
    S_RANGE,
    S_DONE
  } state_e;

  state_e  state_q;
  status_e code_q;
  logic    out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.status    = code_q;
    cmd_o.clr_start = sts_i.cfg_hit;
    case (state_q)
      S_CLEAR:     cmd_o.clr_step   = !sts_i.cfg_hit;
      S_IDLE:      cmd_o.accept     = in_valid_i;
      S_DECODE:    cmd_o.decode     = 1'b1;
      S_ALLOC_CHK: cmd_o.scan_start = !sts_i.zero_size && !sts_i.not_enough;
      S_SCAN:      cmd_o.scan_step  = 1'b1;
      S_ALLOC_SET: cmd_o.alloc_set  = 1'b1;
      S_FREE_RD:   cmd_o.free_rd    = !sts_i.oor;
      S_FREE_CHK:  cmd_o.free_set   = !sts_i.free_ignored;
      S_RANGE:     cmd_o.range_step = 1'b1;
      S_DONE:      cmd_o.load_out   = !out_valid_q || out_ready_i;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (sts_i.cfg_hit) begin
        // any register write re-initializes the pool
        state_q <= S_CLEAR;
      end else begin
        case (state_q)
          S_CLEAR: begin
            if (sts_i.clr_last) state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid_i) state_q <= S_DECODE;
          end
          S_DECODE: begin
            state_q <= sts_i.cmd_free ? S_FREE_RD : S_ALLOC_CHK;
          end
          S_ALLOC_CHK: begin
            if (sts_i.zero_size) begin
              code_q  <= ST_ZERO_SIZE;
              state_q <= S_DONE;
            end else if (sts_i.not_enough) begin
              code_q  <= ST_NOT_ENOUGH;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
          S_SCAN: begin
            if (sts_i.scan_found) begin
              state_q <= S_ALLOC_SET;
            end else if (sts_i.scan_end) begin
              code_q  <= ST_NO_RUN;
              state_q <= S_DONE;
            end
          end
          S_ALLOC_SET: begin
            code_q  <= ST_OK;
            state_q <= S_RANGE;
          end
          S_FREE_RD: begin
            if (sts_i.oor) begin
              code_q  <= ST_OUT_OF_RANGE;
              state_q <= S_DONE;
            end else begin
              state_q <= S_FREE_CHK;
            end
          end
          S_FREE_CHK: begin
            if (sts_i.free_ignored) begin
              code_q  <= ST_FREE_IGNORED;
              state_q <= S_DONE;
            end else begin
              code_q  <= ST_OK;
              state_q <= S_RANGE;
            end
          end
          S_RANGE: begin
            if (sts_i.range_last) state_q <= S_DONE;
          end
          S_DONE: begin
            if (cmd_o.load_out) state_q <= S_IDLE;
          end
          default: state_q <= S_CLEAR;
        endcase
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/contiguous_page_allocator_top.sv
// allocate: decode, size check, scan of the bitmap words (8 pages each, up to
// ceil(pages/8)), then range writes over the words touched by the run; free: decode,
// read, check and the same range writes; one request at a time; the bitmap scan
// covers one word per cycle
// reset and every register write clear the pool one entry per cycle, with
// requests held off; results wait in an output register
// depends on cpa_pkg, cpa_if, cpa_ctrl and cpa_dp

module contiguous_page_allocator_top import cpa_pkg::*; #(
  parameter int MAX_PAGES  = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cpa_req_if.sink   req,
  cpa_rsp_if.source rsp,
  cpa_cfg_if.sink   cfg
);

  cpa_cmd_t cmd;
  cpa_sts_t sts;
  logic     cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  cpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_cmd_i         (req.cmd),
    .in_bytes_i       (req.request_bytes),
    .in_addr_i        (req.release_address),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg.index),
    .cfg_data_i       (cfg.data),
    .status_o         (rsp.status),
    .result_address_o (rsp.result_address),
    .run_pages_o      (rsp.run_pages),
    .free_pages_o     (rsp.free_pages)
  );

endmodule

>>> tb/cpa_checker.sv
// response checker for the contiguous page allocator: keeps its own copy of the pool,
// predicts one response per accepted request and compares the responses in order
// depends on cpa_pkg and cpa_if

module cpa_checker import cpa_pkg::*; #(
  parameter int MAX_PAGES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  cpa_req_if   req,
  cpa_rsp_if   rsp,
  cpa_cfg_if   cfg,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct {
    status_e         status;
    logic [31:0]     addr;
    logic [PAGES_W-1:0] run;
    logic [PAGES_W-1:0] free;
  } outcome_t;

  outcome_t outcome_q[$];

  logic [SHIFT_W-1:0]    page_shift;
  logic [PAGES_W-1:0]    pool_pages;
  logic [RES_ADDR_W-1:0] region_base;

  logic               pool_free [MAX_PAGES];
  logic [PAGES_W-1:0] run_len   [MAX_PAGES];
  int unsigned        free_total;

  function automatic int unsigned shift_used();
    if (page_shift < SHIFT_MIN) return SHIFT_MIN;
    if (page_shift > SHIFT_MAX) return SHIFT_MAX;
    return page_shift;
  endfunction

  function automatic int unsigned pages_used();
    return (pool_pages > MAX_PAGES) ? MAX_PAGES : pool_pages;
  endfunction

  // every valid register write starts the pool over
  task automatic clear_pool();
    foreach (pool_free[i]) begin
      pool_free[i] = 1'b1;
      run_len[i]   = '0;
    end
    free_total = pages_used();
  endtask

  task automatic predict_request(input logic cmd, input logic [31:0] bytes,
                                 input logic [31:0] rel);
    int unsigned sh;
    int unsigned np;
    int unsigned cnt;
    int unsigned first;
    int unsigned idx;
    int unsigned stop;
    logic [32:0] need;
    logic [31:0] offs;
    bit          found;
    outcome_t    o;
    sh       = shift_used();
    np       = pages_used();
    o.status = ST_OK;
    o.addr   = '0;
    o.run    = '0;
    if (cmd == CMD_ALLOC) begin
      need = {1'b0, bytes >> sh} + 33'((bytes & ((32'd1 << sh) - 32'd1)) != 0);
      if (need == 0) begin
        o.status = ST_ZERO_SIZE;
      end else if (free_total < need) begin
        o.status = ST_NOT_ENOUGH;
      end else begin
        // lowest run of free pages that is long enough
        cnt   = 0;
        first = 0;
        found = 1'b0;
        for (int i = 0; i < np && !found; i++) begin
          if (pool_free[i]) begin
            cnt++;
            if (cnt == need) begin
              first = i + 1 - cnt;
              found = 1'b1;
            end
          end else begin
            cnt = 0;
          end
        end
        if (!found) begin
          o.status = ST_NO_RUN;
        end else begin
          for (int i = first; i < first + need; i++) pool_free[i] = 1'b0;
          run_len[first] = need[PAGES_W-1:0];
          free_total    -= need[31:0];
          o.run          = need[PAGES_W-1:0];
          o.addr         = region_base + (32'(first) << sh);
        end
      end
    end else begin
      offs = rel - region_base;
      if (rel < region_base || (offs >> sh) >= np) begin
        o.status = ST_OUT_OF_RANGE;
      end else begin
        idx = offs >> sh;
        if (pool_free[idx] || run_len[idx] == 0) begin
          o.status = ST_FREE_IGNORED;
        end else begin
          stop = idx + run_len[idx];
          if (stop > np) stop = np;
          for (int i = idx; i < stop; i++) pool_free[i] = 1'b1;
          free_total  += stop - idx;
          o.run        = run_len[idx];
          run_len[idx] = '0;
        end
      end
    end
    o.free = free_total[PAGES_W-1:0];
    outcome_q.push_back(o);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift   = SHIFT_RST;
      pool_pages   = PAGES_RST;
      region_base  = BASE_RST;
      clear_pool();
      outcome_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PAGE_SHIFT: begin
            page_shift = cfg.data[SHIFT_W-1:0];
            clear_pool();
          end
          CFG_PAGES: begin
            pool_pages = cfg.data[PAGES_W-1:0];
            clear_pool();
          end
          CFG_BASE: begin
            region_base = cfg.data[RES_ADDR_W-1:0];
            clear_pool();
          end
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected response, expected none actual status %0d addr %0h",
                   $time, rsp.status, rsp.result_address);
          fail_count_o++;
        end else begin
          compare_field("status", 32'(outcome_q[0].status), 32'(rsp.status));
          compare_field("result_address", outcome_q[0].addr, rsp.result_address);
          compare_field("run_pages", 32'(outcome_q[0].run), 32'(rsp.run_pages));
          compare_field("free_pages", 32'(outcome_q[0].free), 32'(rsp.free_pages));
          void'(outcome_q.pop_front());
          checked_o++;
        end
      end
      if (req.valid && req.ready) predict_request(req.cmd, req.request_bytes,
                                                  req.release_address);
    end
    pending_o = outcome_q.size();
  end

endmodule

>>> tb/tb_top.sv
// top of the page allocator testbench: clock, reset, request and config stimulus,
// response backpressure, watchdog and verdict
// depends on cpa_pkg, cpa_if, cpa_checker and contiguous_page_allocator_top

module tb_top;
  import cpa_pkg::*;

  localparam int                   NUM_PHASES  = 10;
  localparam int                   STALL_LIMIT = 5000;
  localparam int                   LONG_HOLD   = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic clk;
  logic rst_n;

  cpa_req_if req_ch ();
  cpa_rsp_if rsp_ch ();
  cpa_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked;

  contiguous_page_allocator_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  cpa_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  int sent;
  int idle_cycles;

  int phase_items [NUM_PHASES] = '{230, 150, 200, 60, 250, 200, 200, 200, 200, 190};

  // pool setting as the stimulus sees it
  int unsigned eff_sh;
  int unsigned eff_np;
  logic [31:0] eff_base;

  logic [31:0] live_q[$];
  cmd_e        issued_cmd_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response backpressure, with an optional long hold
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // remember addresses of granted runs so that most frees hit a run start
  always @(negedge clk) begin
    if (req_ch.valid && req_ch.ready) issued_cmd_q.push_back(cmd_e'(req_ch.cmd));
    if (rsp_ch.valid && rsp_ch.ready && issued_cmd_q.size() != 0) begin
      if (issued_cmd_q[0] == CMD_ALLOC && rsp_ch.status == ST_OK)
        live_q.push_back(rsp_ch.result_address);
      void'(issued_cmd_q.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [31:0] bytes,
                              input logic [31:0] rel);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.cmd             <= cmd;
    req_ch.request_bytes   <= bytes;
    req_ch.release_address <= rel;
    do @(negedge clk); while (!req_ch.ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
  endtask

  task automatic issue_random_request();
    logic [31:0] bytes;
    logic [31:0] rel;
    logic [31:0] span;
    int unsigned need;
    int unsigned pick;
    int unsigned r;
    cmd_e        cmd;
    bytes = $urandom;
    rel   = $urandom;
    span  = 32'd1 << eff_sh;
    r     = $urandom_range(0, 99);
    if (live_q.size() == 0 ? r < 85 : r < 50) begin
      cmd = CMD_ALLOC;
      r   = $urandom_range(0, 99);
      if (r < 3) begin
        bytes = '0;
      end else if (r >= 6) begin
        // sizes near the whole pool now and then, small runs mostly
        if (r < 12) need = $urandom_range(eff_np / 2, eff_np + 2);
        else need = $urandom_range(1, (eff_np > 6) ? eff_np / 6 : 1);
        if (need == 0) need = 1;
        bytes = 32'((need - 1) << eff_sh) + $urandom_range(1, span);
      end
    end else begin
      cmd = CMD_FREE;
      r   = $urandom_range(0, 99);
      if (r < 65 && live_q.size() != 0) begin
        pick = $urandom_range(0, live_q.size() - 1);
        rel  = live_q[pick] + $urandom_range(0, span - 1);
        live_q.delete(pick);
      end else if (r < 82) begin
        rel = eff_base + (32'($urandom_range(0, (eff_np > 0) ? eff_np - 1 : 0)) << eff_sh)
              + $urandom_range(0, span - 1);
      end else if (r < 92) begin
        // just below the base or just past the last page
        if (r[0] && eff_base != 0) rel = eff_base - 32'($urandom_range(1, 256));
        else rel = eff_base + (32'(eff_np) << eff_sh) + $urandom_range(0, span - 1);
      end
    end
    send_request(cmd, bytes, rel);
  endtask

  initial begin
    logic [31:0] shift_w;
    logic [31:0] pages_w;
    logic [31:0] base_w;
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.cmd             = CMD_ALLOC;
    req_ch.request_bytes   = '0;
    req_ch.release_address = '0;
    rsp_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = CFG_PAGE_SHIFT;
    cfg_ch.data            = '0;
    src_idle_pct           = 0;
    snk_idle_pct           = 0;
    hold_left              = 0;
    sent                   = 0;
    idle_cycles            = 0;
    eff_sh                 = SHIFT_RST;
    eff_np                 = PAGES_RST;
    eff_base               = BASE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        case (p)
          1: begin shift_w = 4;  pages_w = 1;   base_w = 32'h0; end
          2: begin shift_w = 16; pages_w = 256; base_w = 32'hFFFF_0000; end
          3: begin shift_w = 0;  pages_w = 0;   base_w = 32'h0000_1000; end
          4: begin shift_w = 31; pages_w = 511; base_w = $urandom & 32'hFFFF_0000; end
          5: begin shift_w = 7;  pages_w = 16;  base_w = $urandom << 7; end
          6: begin shift_w = 12; pages_w = 256; base_w = $urandom; end
          7: begin shift_w = 4;  pages_w = 300; base_w = 32'hFFFF_FFF0; end
          8: begin shift_w = 10; pages_w = 64;  base_w = 32'h8000_0000; end
          default: begin
            shift_w = $urandom_range(0, 31);
            pages_w = $urandom_range(0, 511);
            base_w  = $urandom;
          end
        endcase
        write_register(CFG_PAGE_SHIFT, shift_w);
        write_register(CFG_PAGES, pages_w);
        write_register(CFG_BASE, base_w);
        // index past the register list, must leave the pool alone
        if (p == 5) write_register(CFG_UNUSED, $urandom);
        cfg_ch.valid <= 1'b0;
        eff_sh   = (shift_w[4:0] < SHIFT_MIN) ? SHIFT_MIN :
                   (shift_w[4:0] > SHIFT_MAX) ? SHIFT_MAX : shift_w[4:0];
        eff_np   = (pages_w[8:0] > 256) ? 256 : pages_w[8:0];
        eff_base = base_w;
        live_q.delete();
      end

      @(negedge clk);
      src_idle_pct = (p < 3) ? 38 : (p < 6) ? 86 : 0;
      snk_idle_pct = (p < 3) ? 86 : (p < 6) ? 38 : 0;
      if (p == 1 || p == 7) hold_left = LONG_HOLD;
      @(posedge clk);

      if (p == 0) begin
        // reset pool: 4 KiB pages, 256 of them, base zero
        send_request(CMD_ALLOC, 32'd0, '0);
        send_request(CMD_ALLOC, 32'd1, '0);
        send_request(CMD_ALLOC, 32'd4096, '0);
        send_request(CMD_ALLOC, 32'd4097, '0);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, '0);
        send_request(CMD_FREE, '0, 32'h0000_1000);
        send_request(CMD_FREE, '0, 32'h0000_2001);
        send_request(CMD_FREE, '0, 32'h0000_3000);
        send_request(CMD_FREE, '0, 32'h0000_2000);
        send_request(CMD_FREE, '0, 32'h0010_0000);
        send_request(CMD_FREE, '0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'd12288, '0);
        send_request(CMD_ALLOC, 32'd1024000, '0);
        send_request(CMD_ALLOC, 32'd12288, '0);
        send_request(CMD_FREE, '0, 32'h0000_5000);
        send_request(CMD_FREE, '0, 32'h0000_1000);
        send_request(CMD_ALLOC, 32'd16384, '0);
        send_request(CMD_ALLOC, 32'h0010_0000, '0);
        send_request(CMD_FREE, '0, 32'h0000_0000);
        send_request(CMD_FREE, '0, 32'h0000_4FFF);
        send_request(CMD_ALLOC, 32'h0010_0000, '0);
        send_request(CMD_ALLOC, 32'd1, '0);
        send_request(CMD_FREE, '0, 32'h0000_0000);
      end

      repeat (phase_items[p]) issue_random_request();
      req_ch.valid <= 1'b0;
      do @(negedge clk); while (pending != 0);
      @(posedge clk);
    end

    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d pool settings, saturated, empty and wrapping",
             sent, NUM_PHASES);
    $display("%0d responses checked, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
